[rtl/analog_key_ladder_motor_command_defines.svh]
// Assertion helpers for the keypad motor command block.
// Each check is sampled on the rising edge of clk and is off while rst_n is low.
`ifndef ANALOG_KEY_LADDER_MOTOR_COMMAND_DEFINES_SVH
`define ANALOG_KEY_LADDER_MOTOR_COMMAND_DEFINES_SVH

// Check in the same cycle: when ante holds, cons must hold.
`define AKL_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Delayed check: when ante holds, cons must hold at the next edge.
`define AKL_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/akl_pkg.sv]
`timescale 1ns / 1ps

package akl_pkg;

    localparam int unsigned SAMPLE_W = 12;
    localparam int unsigned NUM_KEYS = 5;

    typedef enum logic [2:0] {
        KEY_0,
        KEY_1,
        KEY_2,
        KEY_3,
        KEY_4,
        KEY_NONE
    } key_t;

    typedef enum logic [2:0] {
        REG_KEY0_CENTRE,
        REG_KEY1_CENTRE,
        REG_KEY2_CENTRE,
        REG_KEY3_CENTRE,
        REG_KEY4_CENTRE,
        REG_TOLERANCE
    } reg_idx_t;

    typedef struct packed {
        logic [NUM_KEYS-1:0][SAMPLE_W-1:0] centre;
        logic [SAMPLE_W-1:0]               tolerance;
    } key_cfg_t;

    localparam logic [SAMPLE_W-1:0] KEY0_CENTRE_RST = 12'd0;
    localparam logic [SAMPLE_W-1:0] KEY1_CENTRE_RST = 12'd564;
    localparam logic [SAMPLE_W-1:0] KEY2_CENTRE_RST = 12'd1215;
    localparam logic [SAMPLE_W-1:0] KEY3_CENTRE_RST = 12'd2075;
    localparam logic [SAMPLE_W-1:0] KEY4_CENTRE_RST = 12'd2300;
    localparam logic [SAMPLE_W-1:0] TOLERANCE_RST   = 12'd65;

    localparam logic signed [8:0] SPEED_STEP = 9'sd10;
    localparam logic signed [7:0] SPEED_MAX  = 8'sd100;
    localparam logic signed [7:0] SPEED_MIN  = -8'sd100;

endpackage

[rtl/analog_key_ladder_motor_command.sv]
`timescale 1ns / 1ps

// Resistor-ladder keypad decoder driving a signed motor speed command.
// Input channel: in_valid / in_stall carry one 12-bit adc_sample per request.
// Output channel: out_valid / out_stall carry one result per request: the
//   decoded key, the signed speed, PWM duty, H-bridge bits and indicator.
// Config port: cfg_we with cfg_index (0..4 key centres, 5 tolerance) and
//   cfg_data; indices 6 and 7 are dropped. Write only while the block is idle.
// Path: a sample is captured in the input register, then decoded and
//   applied to the speed state on its way into the result register.
// Throughput: one sample per cycle while out_stall is low; the window compares
//   and the speed update sit between the input and result registers, one pass per item.
// Stall: while out_stall holds a pending result, the input register keeps its
//   sample and in_stall rises only once that register is also full.
// Reset: no results pending, stored key = none, speed = 0, indicator = 1,
//   registers back to their default centres and tolerance.
`include "analog_key_ladder_motor_command_defines.svh"

module analog_key_ladder_motor_command
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [11:0]         cfg_data,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic [11:0]         adc_sample,

    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          key_index,
    output logic signed [7:0]   speed_setting,
    output logic [6:0]          duty,
    output logic                bridge_a,
    output logic                bridge_b,
    output logic                indicator
);

    // configuration registers
    akl_pkg::key_cfg_t  cfg_reg;

    // input register
    logic               s1_valid_reg, s1_valid_next;
    logic [11:0]        sample_reg;

    // result register valid; payload lives in the state block
    logic               out_valid_reg, out_valid_next;

    logic               advance;
    logic               s1_load;
    logic               take_in;
    akl_pkg::key_t      dec_key;
    akl_pkg::key_t      last_key;

    // advance the result register when it is empty or being taken
    assign advance  = !out_valid_reg || !out_stall;
    assign s1_load  = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;
    assign take_in  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take_in)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_load)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the sample in the input register until it moves on
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            sample_reg <= adc_sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.centre[0] <= akl_pkg::KEY0_CENTRE_RST;
            cfg_reg.centre[1] <= akl_pkg::KEY1_CENTRE_RST;
            cfg_reg.centre[2] <= akl_pkg::KEY2_CENTRE_RST;
            cfg_reg.centre[3] <= akl_pkg::KEY3_CENTRE_RST;
            cfg_reg.centre[4] <= akl_pkg::KEY4_CENTRE_RST;
            cfg_reg.tolerance <= akl_pkg::TOLERANCE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                akl_pkg::REG_KEY0_CENTRE: cfg_reg.centre[0] <= cfg_data;
                akl_pkg::REG_KEY1_CENTRE: cfg_reg.centre[1] <= cfg_data;
                akl_pkg::REG_KEY2_CENTRE: cfg_reg.centre[2] <= cfg_data;
                akl_pkg::REG_KEY3_CENTRE: cfg_reg.centre[3] <= cfg_data;
                akl_pkg::REG_KEY4_CENTRE: cfg_reg.centre[4] <= cfg_data;
                akl_pkg::REG_TOLERANCE:   cfg_reg.tolerance <= cfg_data;
                default:
                begin
                    // drop writes to unused indices
                end
            endcase
        end
    end

    akl_decode u_decode
    (
        .sample    (sample_reg),
        .cfg       (cfg_reg),
        .key       (dec_key)
    );

    // the state block doubles as the result payload register
    akl_state u_state
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s1_load),
        .key       (dec_key),
        .last_key  (last_key),
        .speed     (speed_setting),
        .duty      (duty),
        .bridge_a  (bridge_a),
        .bridge_b  (bridge_b),
        .indicator (indicator)
    );

    assign out_valid = out_valid_reg;
    assign key_index = last_key;

    `AKL_CHECK_NOW(a_duty_matches_bridge, 1'b1,
        ((duty == 7'd0) == (!bridge_a && !bridge_b)) && !(bridge_a && bridge_b),
        "duty and bridge bits disagree")
    `AKL_CHECK_NOW(a_speed_in_range, 1'b1,
        (speed_setting <= akl_pkg::SPEED_MAX) && (speed_setting >= akl_pkg::SPEED_MIN),
        "speed outside limits")
    `AKL_CHECK_NEXT(a_same_key_holds, s1_load && (dec_key == last_key),
        $stable(speed_setting) && $stable(indicator),
        "repeated key changed state")
    `AKL_CHECK_NOW(a_stall_only_when_full, in_stall,
        s1_valid_reg && out_valid_reg && out_stall,
        "input stalled with room in the pipe")

endmodule

[rtl/akl_decode.sv]
`timescale 1ns / 1ps

// Window match of one sample against the five key centres; lowest key wins.
module akl_decode
(
    input  logic [11:0]             sample,
    input  akl_pkg::key_cfg_t       cfg,
    output akl_pkg::key_t           key
);

    logic [akl_pkg::NUM_KEYS-1:0] hit;

    always_comb
    begin
        for (int i = 0; i < akl_pkg::NUM_KEYS; i++)
        begin
            // sample in [c - tol, c + tol], compared at 13 bits so nothing wraps
            hit[i] = ({1'b0, sample} <= ({1'b0, cfg.centre[i]} + {1'b0, cfg.tolerance}))
                  && (({1'b0, sample} + {1'b0, cfg.tolerance}) >= {1'b0, cfg.centre[i]});
        end
    end

    always_comb
    begin
        key = akl_pkg::KEY_NONE;
        for (int i = akl_pkg::NUM_KEYS - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                key = akl_pkg::key_t'(3'(i));
            end
        end
    end

endmodule

[rtl/akl_state.sv]
`timescale 1ns / 1ps

// Key-change state: stored key, speed, indicator, plus registered drive outputs.
module akl_state
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  akl_pkg::key_t       key,
    output akl_pkg::key_t       last_key,
    output logic signed [7:0]   speed,
    output logic [6:0]          duty,
    output logic                bridge_a,
    output logic                bridge_b,
    output logic                indicator
);

    akl_pkg::key_t      last_key_reg, last_key_next;
    logic signed [7:0]  speed_level_reg, speed_level_next;
    logic               indicator_reg, indicator_next;
    logic [6:0]         duty_reg, duty_next;
    logic               bridge_a_reg, bridge_a_next;
    logic               bridge_b_reg, bridge_b_next;

    logic signed [8:0]  speed_up;
    logic signed [8:0]  speed_down;
    logic signed [7:0]  speed_mag;

    assign speed_up   = 9'(speed_level_reg) + akl_pkg::SPEED_STEP;
    assign speed_down = 9'(speed_level_reg) - akl_pkg::SPEED_STEP;

    always_comb
    begin
        last_key_next    = last_key_reg;
        speed_level_next = speed_level_reg;
        indicator_next   = indicator_reg;
        if (load && (key != last_key_reg))
        begin
            last_key_next = key;
            case (key)
                akl_pkg::KEY_0:
                begin
                    speed_level_next = '0;
                    indicator_next   = ~indicator_reg;
                end
                akl_pkg::KEY_1:
                begin
                    if (speed_level_reg < akl_pkg::SPEED_MAX)
                    begin
                        speed_level_next = (speed_up > 9'(akl_pkg::SPEED_MAX))
                                         ? akl_pkg::SPEED_MAX : speed_up[7:0];
                    end
                    indicator_next = ~indicator_reg;
                end
                akl_pkg::KEY_2:
                begin
                    if (speed_level_reg > akl_pkg::SPEED_MIN)
                    begin
                        speed_level_next = (speed_down < 9'(akl_pkg::SPEED_MIN))
                                         ? akl_pkg::SPEED_MIN : speed_down[7:0];
                    end
                    indicator_next = ~indicator_reg;
                end
                akl_pkg::KEY_3:
                begin
                    indicator_next = ~indicator_reg;
                end
                default:
                begin
                    indicator_next = indicator_reg;
                end
            endcase
        end
    end

    // magnitude of the new speed; range is held to +/-100 so it fits 7 bits
    assign speed_mag     = (speed_level_next < 0) ? -speed_level_next : speed_level_next;
    assign duty_next     = speed_mag[6:0];
    assign bridge_a_next = (speed_level_next < 0);
    assign bridge_b_next = (speed_level_next > 0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_key_reg    <= akl_pkg::KEY_NONE;
            speed_level_reg <= '0;
            indicator_reg   <= 1'b1;
            duty_reg        <= '0;
            bridge_a_reg    <= 1'b0;
            bridge_b_reg    <= 1'b0;
        end
        else
        begin
            last_key_reg    <= last_key_next;
            speed_level_reg <= speed_level_next;
            indicator_reg   <= indicator_next;
            duty_reg        <= duty_next;
            bridge_a_reg    <= bridge_a_next;
            bridge_b_reg    <= bridge_b_next;
        end
    end

    assign last_key  = last_key_reg;
    assign speed     = speed_level_reg;
    assign duty      = duty_reg;
    assign bridge_a  = bridge_a_reg;
    assign bridge_b  = bridge_b_reg;
    assign indicator = indicator_reg;

endmodule
